// File: hdl/wtce_pkg.sv
package wtce_pkg;

    localparam int FRAME_LEN   = 60;
    localparam int INDEX_W     = 6;
    localparam int MS_W        = 10;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MS_W-1:0] MS_MARK   = 10'd800;
    localparam logic [MS_W-1:0] MS_ONE    = 10'd500;
    localparam logic [MS_W-1:0] MS_ZERO   = 10'd200;
    localparam logic [MS_W-1:0] MS_FULL_MARK = 10'd200;
    localparam logic [MS_W-1:0] MS_FULL_ONE  = 10'd500;
    localparam logic [MS_W-1:0] MS_FULL_ZERO = 10'd800;

    localparam logic [INDEX_W-1:0] LAST_INDEX = 6'd59;

    typedef enum logic [1:0] {
        KIND_ZERO = 2'd0,
        KIND_ONE  = 2'd1,
        KIND_MARK = 2'd2
    } t_kind;

    // one bit per second, set where the frame carries a one
    typedef logic [FRAME_LEN-1:0] t_frame;

    typedef struct packed {
        t_kind             kind;
        logic [INDEX_W-1:0] index;
        logic [MS_W-1:0]    reduced_ms;
        logic [MS_W-1:0]    full_ms;
        logic               last;
    } t_symbol;

    function automatic logic is_marker(input logic [INDEX_W-1:0] idx);
        is_marker = (idx == 6'd0)  || (idx == 6'd9)  || (idx == 6'd19) ||
                    (idx == 6'd29) || (idx == 6'd39) || (idx == 6'd49) ||
                    (idx == 6'd59);
    endfunction

    function automatic logic [MS_W-1:0] reduced_of(input t_kind k);
        case (k)
            KIND_MARK: reduced_of = MS_MARK;
            KIND_ONE:  reduced_of = MS_ONE;
            default:   reduced_of = MS_ZERO;
        endcase
    endfunction

    function automatic logic [MS_W-1:0] full_of(input t_kind k);
        case (k)
            KIND_MARK: full_of = MS_FULL_MARK;
            KIND_ONE:  full_of = MS_FULL_ONE;
            default:   full_of = MS_FULL_ZERO;
        endcase
    endfunction

endpackage

// File: hdl/wtce_front.sv
module wtce_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [5:0]          i_minute,
    input  logic [4:0]          i_hour,
    input  logic [8:0]          i_day_of_year,
    input  logic [6:0]          i_year_two_digit,
    input  logic                i_dst_now,
    input  logic                i_dst_next,
    output logic                o_push_valid,
    input  logic                i_push_ready,
    output wtce_pkg::t_frame    o_frame
);

    // tens digit of a value below 100, by reciprocal multiply
    function automatic logic [3:0] tens_of(input logic [6:0] v);
        logic [14:0] prod;
        prod    = 15'(v) * 15'd205;
        tens_of = prod[14:11];
    endfunction

    function automatic logic [3:0] ones_of(input logic [6:0] v, input logic [3:0] t);
        logic [6:0] diff;
        diff    = v - 7'(t) * 7'd10;
        ones_of = diff[3:0];
    endfunction

    logic        r_valid;
    wtce_pkg::t_frame r_frame;
    wtce_pkg::t_frame n_frame;

    logic [5:0]  minute_c;
    logic [4:0]  hour_c;
    logic [8:0]  day_c;
    logic [6:0]  year_c;
    logic [1:0]  day_hund;
    logic [8:0]  day_rem9;
    logic [6:0]  day_rem;
    logic [3:0]  min_t, min_o, hour_t, hour_o, day_t, day_o, year_t, year_o;

    assign o_ready      = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_frame      = r_frame;

    always_comb begin
        minute_c = (i_minute > 6'd59) ? 6'd59 : i_minute;
        hour_c   = (i_hour > 5'd23) ? 5'd23 : i_hour;
        year_c   = (i_year_two_digit > 7'd99) ? 7'd99 : i_year_two_digit;
        if (i_day_of_year == 9'd0) begin
            day_c = 9'd1;
        end else if (i_day_of_year > 9'd366) begin
            day_c = 9'd366;
        end else begin
            day_c = i_day_of_year;
        end

        if (day_c >= 9'd300) begin
            day_hund = 2'd3;
            day_rem9 = day_c - 9'd300;
        end else if (day_c >= 9'd200) begin
            day_hund = 2'd2;
            day_rem9 = day_c - 9'd200;
        end else if (day_c >= 9'd100) begin
            day_hund = 2'd1;
            day_rem9 = day_c - 9'd100;
        end else begin
            day_hund = 2'd0;
            day_rem9 = day_c;
        end
        day_rem = day_rem9[6:0];

        min_t  = tens_of(7'(minute_c));
        min_o  = ones_of(7'(minute_c), min_t);
        hour_t = tens_of(7'(hour_c));
        hour_o = ones_of(7'(hour_c), hour_t);
        day_t  = tens_of(day_rem);
        day_o  = ones_of(day_rem, day_t);
        year_t = tens_of(year_c);
        year_o = ones_of(year_c, year_t);

        // bcd fields go msb first in rising second order
        n_frame     = '0;
        n_frame[1]  = min_t[2];
        n_frame[2]  = min_t[1];
        n_frame[3]  = min_t[0];
        n_frame[5]  = min_o[3];
        n_frame[6]  = min_o[2];
        n_frame[7]  = min_o[1];
        n_frame[8]  = min_o[0];
        n_frame[12] = hour_t[1];
        n_frame[13] = hour_t[0];
        n_frame[15] = hour_o[3];
        n_frame[16] = hour_o[2];
        n_frame[17] = hour_o[1];
        n_frame[18] = hour_o[0];
        n_frame[22] = day_hund[1];
        n_frame[23] = day_hund[0];
        n_frame[25] = day_t[3];
        n_frame[26] = day_t[2];
        n_frame[27] = day_t[1];
        n_frame[28] = day_t[0];
        n_frame[30] = day_o[3];
        n_frame[31] = day_o[2];
        n_frame[32] = day_o[1];
        n_frame[33] = day_o[0];
        n_frame[37] = 1'b1;
        n_frame[45] = year_t[3];
        n_frame[46] = year_t[2];
        n_frame[47] = year_t[1];
        n_frame[48] = year_t[0];
        n_frame[50] = year_o[3];
        n_frame[51] = year_o[2];
        n_frame[52] = year_o[1];
        n_frame[53] = year_o[0];
        n_frame[55] = (year_c[1:0] == 2'd0);
        n_frame[57] = i_dst_next;
        n_frame[58] = i_dst_now;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_frame <= n_frame;
        end
    end

endmodule

// File: hdl/wtce_queue.sv
module wtce_queue #(
    parameter int DEPTH = wtce_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_push_ready,
    input  wtce_pkg::t_frame i_frame,
    output logic             o_valid,
    input  logic             i_pop,
    output wtce_pkg::t_frame o_frame
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    wtce_pkg::t_frame r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_push_ready = (r_count != CNT_W'(DEPTH));
    assign o_valid      = (r_count != '0);
    assign o_frame      = r_mem[r_rd_ptr];
    assign do_push      = i_push && o_push_ready;
    assign do_pop       = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_frame;
        end
    end

endmodule

// File: hdl/wtce_back.sv
module wtce_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  wtce_pkg::t_frame  i_frame,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output wtce_pkg::t_symbol o_symbol
);

    logic [wtce_pkg::INDEX_W-1:0] r_cnt;
    logic                         r_valid;
    wtce_pkg::t_symbol            r_symbol;
    wtce_pkg::t_symbol            n_symbol;
    logic                         advance;
    logic                         emit;
    wtce_pkg::t_kind              kind;

    assign advance  = !r_valid || i_ready;
    assign emit     = advance && i_valid;
    assign o_pop    = emit && (r_cnt == wtce_pkg::LAST_INDEX);
    assign o_valid  = r_valid;
    assign o_symbol = r_symbol;

    always_comb begin
        if (wtce_pkg::is_marker(r_cnt)) begin
            kind = wtce_pkg::KIND_MARK;
        end else if (i_frame[r_cnt]) begin
            kind = wtce_pkg::KIND_ONE;
        end else begin
            kind = wtce_pkg::KIND_ZERO;
        end
        n_symbol.kind       = kind;
        n_symbol.index      = r_cnt;
        n_symbol.reduced_ms = wtce_pkg::reduced_of(kind);
        n_symbol.full_ms    = wtce_pkg::full_of(kind);
        n_symbol.last       = (r_cnt == wtce_pkg::LAST_INDEX);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else if (advance) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_cnt <= (r_cnt == wtce_pkg::LAST_INDEX) ? '0 : r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_symbol <= n_symbol;
        end
    end

endmodule

// File: hdl/wwvb_time_code_frame_encoder.sv
// path: front frame register, frame queue, then the output symbol register
// throughput: 60 symbols per time stamp, one a cycle unless the sink stalls
// a two-entry frame queue lets the next time stamp be taken while a frame still plays out
// reset: synchronous active low, clears valid flags, queue pointers and symbol counter
module wwvb_time_code_frame_encoder #(
    parameter int QUEUE_DEPTH = wtce_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // minute[5:0], hour[10:6], day_of_year[19:11], year_two_digit[26:20],
    // dst_now[27], dst_next[28], zero[31:29]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // symbol_index[5:0], reduced_ms[15:6], full_ms[25:16], zero[31:26]
    output logic [31:0] m_axis_tdata,
    // symbol_kind[1:0]
    output logic [1:0]  m_axis_tuser,
    output logic        m_axis_tlast
);

    logic              push_valid, push_ready;
    wtce_pkg::t_frame  push_frame, head_frame;
    logic              head_valid, pop;
    wtce_pkg::t_symbol symbol;

    wtce_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_minute         (s_axis_tdata[5:0]),
        .i_hour           (s_axis_tdata[10:6]),
        .i_day_of_year    (s_axis_tdata[19:11]),
        .i_year_two_digit (s_axis_tdata[26:20]),
        .i_dst_now        (s_axis_tdata[27]),
        .i_dst_next       (s_axis_tdata[28]),
        .o_push_valid     (push_valid),
        .i_push_ready     (push_ready),
        .o_frame          (push_frame)
    );

    wtce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push_valid),
        .o_push_ready (push_ready),
        .i_frame      (push_frame),
        .o_valid      (head_valid),
        .i_pop        (pop),
        .o_frame      (head_frame)
    );

    wtce_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (head_valid),
        .i_frame  (head_frame),
        .o_pop    (pop),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_symbol (symbol)
    );

    assign m_axis_tdata = {6'd0, symbol.full_ms, symbol.reduced_ms, symbol.index};
    assign m_axis_tuser = symbol.kind;
    assign m_axis_tlast = symbol.last;

endmodule

// File: hdl/wtce_checker.sv
module wtce_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output changed while stalled");

    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            ({1'b0, m_axis_tdata[15:6]} + {1'b0, m_axis_tdata[25:16]}) == 11'd1000)
        else $error("reduced and full carrier times do not fill one second");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tlast == (m_axis_tdata[5:0] == 6'd59)))
        else $error("tlast not on second 59");

    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[5:0] == 6'd0 || m_axis_tdata[5:0] == 6'd9 ||
            m_axis_tdata[5:0] == 6'd19 || m_axis_tdata[5:0] == 6'd29 ||
            m_axis_tdata[5:0] == 6'd39 || m_axis_tdata[5:0] == 6'd49 ||
            m_axis_tdata[5:0] == 6'd59) |->
            m_axis_tuser == wtce_pkg::KIND_MARK && m_axis_tdata[15:6] == 10'd800)
        else $error("marker second without marker symbol");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid |->
            m_axis_tdata[5:0] == $past(m_axis_tdata[5:0]) + 6'd1)
        else $error("symbol index did not advance by one");

endmodule

bind wwvb_time_code_frame_encoder wtce_checker u_wtce_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tb_wwvb_time_code_frame_encoder.sv
module tb_wwvb_time_code_frame_encoder;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED = 20;
    localparam int NUM_RANDOM   = 440;
    localparam int CHUNK        = 40;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 10;
    localparam logic [wtce_pkg::MS_W-1:0] MS_SECOND = 10'd1000;
    // seconds 0, 9, 19, 29, 39, 49 and 59
    localparam logic [59:0] MARKER_MASK = 60'h802_0080_2008_0201;

    typedef struct packed {
        logic [5:0] minute;
        logic [4:0] hour;
        logic [8:0] day;
        logic [6:0] year;
        logic       dst_now;
        logic       dst_next;
    } t_stamp;

    typedef struct {
        t_stamp raw;
        bit     typed;
        t_stamp clamped;
    } t_directed_row;

    typedef struct {
        wtce_pkg::t_kind              kind;
        logic [wtce_pkg::INDEX_W-1:0] index;
        logic [wtce_pkg::MS_W-1:0]    reduced_ms;
        logic [wtce_pkg::MS_W-1:0]    full_ms;
        logic                         is_last;
    } t_exp_symbol;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;

    t_exp_symbol   pending_symbols[$];
    t_directed_row directed_rows[NUM_DIRECTED];
    int  error_count = 0;
    int  idle_cycles = 0;
    int  stall_left = 0;
    int  stamps_sent = 0;
    int  stamps_clamped = 0;
    int  symbols_checked = 0;
    bit  send_gaps = 1'b0;
    bit  recv_stalls = 1'b0;

    wwvb_time_code_frame_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_stamp clamp_stamp(input t_stamp st);
        t_stamp c;
        c = st;
        if (st.minute > 6'd59) c.minute = 6'd59;
        if (st.hour > 5'd23) c.hour = 5'd23;
        if (st.day == 9'd0) c.day = 9'd1;
        if (st.day > 9'd366) c.day = 9'd366;
        if (st.year > 7'd99) c.year = 7'd99;
        return c;
    endfunction

    // digit goes msb first starting at second 'first'
    function automatic void place_bcd(inout logic [59:0] ones, input int first, input int n,
                                      input int digit);
        for (int i = 0; i < n; i++) begin
            ones[first + i] = 1'((digit >> (n - 1 - i)) & 1);
        end
    endfunction

    // builds the sixty symbols of a frame from an already clamped time stamp
    function automatic void queue_frame_symbols(input t_stamp c);
        logic [59:0] ones;
        t_exp_symbol sym;
        int          mn;
        int          hr;
        int          dy;
        int          yr;
        mn = c.minute;
        hr = c.hour;
        dy = c.day;
        yr = c.year;
        ones = '0;
        place_bcd(ones, 1, 3, mn / 10);
        place_bcd(ones, 5, 4, mn % 10);
        place_bcd(ones, 12, 2, hr / 10);
        place_bcd(ones, 15, 4, hr % 10);
        place_bcd(ones, 22, 2, dy / 100);
        place_bcd(ones, 25, 4, (dy / 10) % 10);
        place_bcd(ones, 30, 4, dy % 10);
        // dut1 sign is fixed at 0,1,0
        ones[37] = 1'b1;
        place_bcd(ones, 45, 4, yr / 10);
        place_bcd(ones, 50, 4, yr % 10);
        ones[55] = (yr % 4) == 0;
        ones[57] = c.dst_next;
        ones[58] = c.dst_now;
        for (int s = 0; s < wtce_pkg::FRAME_LEN; s++) begin
            if (MARKER_MASK[s]) begin
                sym.kind = wtce_pkg::KIND_MARK;
                sym.reduced_ms = wtce_pkg::MS_MARK;
            end else if (ones[s]) begin
                sym.kind = wtce_pkg::KIND_ONE;
                sym.reduced_ms = wtce_pkg::MS_ONE;
            end else begin
                sym.kind = wtce_pkg::KIND_ZERO;
                sym.reduced_ms = wtce_pkg::MS_ZERO;
            end
            sym.index = s[wtce_pkg::INDEX_W-1:0];
            sym.full_ms = MS_SECOND - sym.reduced_ms;
            sym.is_last = (s == wtce_pkg::FRAME_LEN - 1);
            pending_symbols.push_back(sym);
        end
    endfunction

    function automatic int gap_length();
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_stamp(input t_stamp st, input bit typed, input t_stamp typed_clamp);
        t_stamp c;
        if (send_gaps && $urandom_range(0, 2) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap_length()) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, st.dst_next, st.dst_now, st.year, st.day, st.hour, st.minute};
        do @(posedge i_clk); while (!s_axis_tready);
        c = typed ? typed_clamp : clamp_stamp(st);
        if (c != st) stamps_clamped++;
        stamps_sent++;
        queue_frame_symbols(c);
    endtask

    function automatic t_stamp random_stamp();
        t_stamp st;
        int     pick;
        pick = int'($urandom_range(0, 9));
        st.dst_now  = 1'($urandom_range(0, 1));
        st.dst_next = 1'($urandom_range(0, 1));
        if (pick < 7) begin
            st.minute = 6'($urandom_range(0, 59));
            st.hour   = 5'($urandom_range(0, 23));
            st.day    = 9'($urandom_range(1, 366));
            st.year   = 7'($urandom_range(0, 99));
        end else if (pick < 9) begin
            st.minute = 6'($urandom);
            st.hour   = 5'($urandom);
            st.day    = 9'($urandom);
            st.year   = 7'($urandom);
        end else begin
            // boundary values on either side of each clamp
            case ($urandom_range(0, 3))
                0: st.minute = 6'd0;
                1: st.minute = 6'd59;
                2: st.minute = 6'd60;
                default: st.minute = 6'd63;
            endcase
            case ($urandom_range(0, 3))
                0: st.hour = 5'd0;
                1: st.hour = 5'd23;
                2: st.hour = 5'd24;
                default: st.hour = 5'd31;
            endcase
            case ($urandom_range(0, 4))
                0: st.day = 9'd0;
                1: st.day = 9'd1;
                2: st.day = 9'd366;
                3: st.day = 9'd367;
                default: st.day = 9'd511;
            endcase
            case ($urandom_range(0, 3))
                0: st.year = 7'd0;
                1: st.year = 7'd99;
                2: st.year = 7'd100;
                default: st.year = 7'd127;
            endcase
        end
        return st;
    endfunction

    // output side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (recv_stalls && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            stall_left <= gap_length() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_exp_symbol exp_sym;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_symbols.size() == 0) begin
                $error("symbol transfer with nothing expected: index %0d", m_axis_tdata[5:0]);
                error_count++;
            end else begin
                exp_sym = pending_symbols.pop_front();
                symbols_checked++;
                if (m_axis_tuser !== exp_sym.kind) begin
                    $error("symbol_kind mismatch: expected %0d, got %0d",
                           exp_sym.kind, m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[5:0] !== exp_sym.index) begin
                    $error("symbol_index mismatch: expected %0d, got %0d",
                           exp_sym.index, m_axis_tdata[5:0]);
                    error_count++;
                end
                if (m_axis_tdata[15:6] !== exp_sym.reduced_ms) begin
                    $error("reduced_ms mismatch: expected %0d, got %0d",
                           exp_sym.reduced_ms, m_axis_tdata[15:6]);
                    error_count++;
                end
                if (m_axis_tdata[25:16] !== exp_sym.full_ms) begin
                    $error("full_ms mismatch: expected %0d, got %0d",
                           exp_sym.full_ms, m_axis_tdata[25:16]);
                    error_count++;
                end
                if (m_axis_tlast !== exp_sym.is_last) begin
                    $error("last mismatch: expected %0d, got %0d",
                           exp_sym.is_last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial begin
        t_stamp st;
        t_stamp none;
        none = '{default: '0};
        // minute, hour, day, year, dst now, dst next; clamped values where typed
        directed_rows = '{
            '{'{6'd0,  5'd0,  9'd0,   7'd0,   1'b0, 1'b0}, 1'b1,
              '{6'd0,  5'd0,  9'd1,   7'd0,   1'b0, 1'b0}},
            '{'{6'd59, 5'd23, 9'd366, 7'd99,  1'b1, 1'b1}, 1'b1,
              '{6'd59, 5'd23, 9'd366, 7'd99,  1'b1, 1'b1}},
            '{'{6'd63, 5'd31, 9'd511, 7'd127, 1'b1, 1'b1}, 1'b1,
              '{6'd59, 5'd23, 9'd366, 7'd99,  1'b1, 1'b1}},
            '{'{6'd60, 5'd24, 9'd367, 7'd100, 1'b0, 1'b1}, 1'b1,
              '{6'd59, 5'd23, 9'd366, 7'd99,  1'b0, 1'b1}},
            '{'{6'd0,  5'd0,  9'd1,   7'd0,   1'b1, 1'b0}, 1'b1,
              '{6'd0,  5'd0,  9'd1,   7'd0,   1'b1, 1'b0}},
            '{'{6'd59, 5'd0,  9'd1,   7'd1,   1'b0, 1'b0}, 1'b1,
              '{6'd59, 5'd0,  9'd1,   7'd1,   1'b0, 1'b0}},
            '{'{6'd0,  5'd23, 9'd366, 7'd4,   1'b0, 1'b0}, 1'b1,
              '{6'd0,  5'd23, 9'd366, 7'd4,   1'b0, 1'b0}},
            '{'{6'd37, 5'd19, 9'd100, 7'd96,  1'b1, 1'b1}, 1'b0, none},
            '{'{6'd45, 5'd12, 9'd199, 7'd23,  1'b0, 1'b1}, 1'b0, none},
            '{'{6'd8,  5'd9,  9'd255, 7'd50,  1'b1, 1'b0}, 1'b0, none},
            '{'{6'd31, 5'd16, 9'd365, 7'd88,  1'b0, 1'b0}, 1'b0, none},
            '{'{6'd42, 5'd3,  9'd60,  7'd7,   1'b1, 1'b1}, 1'b0, none},
            '{'{6'd21, 5'd10, 9'd288, 7'd64,  1'b0, 1'b1}, 1'b0, none},
            '{'{6'd0,  5'd0,  9'd366, 7'd0,   1'b0, 1'b0}, 1'b1,
              '{6'd0,  5'd0,  9'd366, 7'd0,   1'b0, 1'b0}},
            '{'{6'd52, 5'd21, 9'd511, 7'd0,   1'b1, 1'b1}, 1'b1,
              '{6'd52, 5'd21, 9'd366, 7'd0,   1'b1, 1'b1}},
            '{'{6'd61, 5'd7,  9'd0,   7'd98,  1'b0, 1'b0}, 1'b1,
              '{6'd59, 5'd7,  9'd1,   7'd98,  1'b0, 1'b0}},
            '{'{6'd14, 5'd25, 9'd33,  7'd126, 1'b1, 1'b0}, 1'b1,
              '{6'd14, 5'd23, 9'd33,  7'd99,  1'b1, 1'b0}},
            '{'{6'd1,  5'd1,  9'd10,  7'd11,  1'b0, 1'b1}, 1'b0, none},
            '{'{6'd27, 5'd14, 9'd222, 7'd75,  1'b1, 1'b0}, 1'b0, none},
            '{'{6'd58, 5'd22, 9'd333, 7'd40,  1'b0, 1'b1}, 1'b0, none}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows run back to back with a free-running sink
        foreach (directed_rows[r]) begin
            send_stamp(directed_rows[r].raw, directed_rows[r].typed, directed_rows[r].clamped);
        end

        for (int n = 0; n < NUM_RANDOM; n++) begin
            if (n % CHUNK == 0) begin
                send_gaps   = 1'($urandom_range(0, 1));
                recv_stalls = 1'($urandom_range(0, 1));
            end
            st = random_stamp();
            send_stamp(st, 1'b0, none);
        end
        s_axis_tvalid <= 1'b0;

        while (pending_symbols.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("%0d time stamps sent (%0d out of range and clamped), %0d symbols checked",
                 stamps_sent, stamps_clamped, symbols_checked);
        $display("input and output stalls varied in blocks of %0d time stamps", CHUNK);
        if (error_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

// File: sim.f
hdl/wtce_pkg.sv
hdl/wtce_front.sv
hdl/wtce_queue.sv
hdl/wtce_back.sv
hdl/wwvb_time_code_frame_encoder.sv
hdl/wtce_checker.sv
tb/tb_wwvb_time_code_frame_encoder.sv
